FILE: src/scr_pkg.sv
package scr_pkg;

   localparam int MAX_DIMS  = 8;
   localparam int COORD_W   = 32;
   localparam int VALUE_W   = 64;
   localparam int KEY_W     = 64;
   localparam int NDIM_W    = 4;
   localparam int DIDX_W    = 3;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_DIM_COUNT = 3'd0;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_LOAD,
      DP_SMUL_LO,
      DP_SMUL_HI,
      DP_SFIX,
      DP_CMUL_LO,
      DP_CMUL_HI,
      DP_KFIX,
      DP_INS_RD,
      DP_INS_MOVE,
      DP_INS_PUT,
      DP_COMMIT,
      DP_EMIT_RD,
      DP_EMIT_SLOT,
      DP_EMIT_LOAD,
      DP_EMIT_NEXT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic full;
      logic last;
      logic dim_zero;
      logic pos_zero;
      logic key_gt;
      logic k_last;
   } dp_status_type;

endpackage

FILE: src/sparse_coordinate_reorder.sv
// channel  | handshake             | payload
// req_     | req_valid / req_stall | req_coord_0..7, req_entry_value, req_last_entry
// rsp_     | rsp_valid / rsp_stall | rsp_out_coord_0..7, rsp_out_value, rsp_out_last
// csr_     | csr_valid / csr_ready | csr_index, csr_data
//
// an entry's key is formed one dim in use at a time (one shared 32x32
// multiplier), then insertion moves each stored entry with a larger key up one
// slot until the entry lands at its place, then a commit step. the flush reads
// each result beat and holds it while rsp_stall is high.
// req_stall is high from acceptance until the entry is placed or the flush ends.
// reset is synchronous and empties the store; no clearing pass is needed.
module sparse_coordinate_reorder #(
   parameter int MAX_ENTRIES = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [scr_pkg::COORD_W-1:0]     req_coord_0,
   input  logic [scr_pkg::COORD_W-1:0]     req_coord_1,
   input  logic [scr_pkg::COORD_W-1:0]     req_coord_2,
   input  logic [scr_pkg::COORD_W-1:0]     req_coord_3,
   input  logic [scr_pkg::COORD_W-1:0]     req_coord_4,
   input  logic [scr_pkg::COORD_W-1:0]     req_coord_5,
   input  logic [scr_pkg::COORD_W-1:0]     req_coord_6,
   input  logic [scr_pkg::COORD_W-1:0]     req_coord_7,
   input  logic [scr_pkg::VALUE_W-1:0]     req_entry_value,
   input  logic                            req_last_entry,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [scr_pkg::COORD_W-1:0]     rsp_out_coord_0,
   output logic [scr_pkg::COORD_W-1:0]     rsp_out_coord_1,
   output logic [scr_pkg::COORD_W-1:0]     rsp_out_coord_2,
   output logic [scr_pkg::COORD_W-1:0]     rsp_out_coord_3,
   output logic [scr_pkg::COORD_W-1:0]     rsp_out_coord_4,
   output logic [scr_pkg::COORD_W-1:0]     rsp_out_coord_5,
   output logic [scr_pkg::COORD_W-1:0]     rsp_out_coord_6,
   output logic [scr_pkg::COORD_W-1:0]     rsp_out_coord_7,
   output logic [scr_pkg::VALUE_W-1:0]     rsp_out_value,
   output logic                            rsp_out_last,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [scr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [scr_pkg::CSR_DAT_W-1:0]   csr_data
);
   import scr_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic [COORD_W-1:0] in_coord  [MAX_DIMS];
   logic [COORD_W-1:0] out_coord [MAX_DIMS];

   assign in_coord[0] = req_coord_0;
   assign in_coord[1] = req_coord_1;
   assign in_coord[2] = req_coord_2;
   assign in_coord[3] = req_coord_3;
   assign in_coord[4] = req_coord_4;
   assign in_coord[5] = req_coord_5;
   assign in_coord[6] = req_coord_6;
   assign in_coord[7] = req_coord_7;

   assign rsp_out_coord_0 = out_coord[0];
   assign rsp_out_coord_1 = out_coord[1];
   assign rsp_out_coord_2 = out_coord[2];
   assign rsp_out_coord_3 = out_coord[3];
   assign rsp_out_coord_4 = out_coord[4];
   assign rsp_out_coord_5 = out_coord[5];
   assign rsp_out_coord_6 = out_coord[6];
   assign rsp_out_coord_7 = out_coord[7];

   assign csr_ready = 1'b1;

   scr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   scr_dp #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .csr_we    (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .in_coord  (in_coord),
      .in_value  (req_entry_value),
      .in_last   (req_last_entry),
      .out_coord (out_coord),
      .out_value (rsp_out_value),
      .out_last  (rsp_out_last)
   );
endmodule

FILE: src/scr_ram.sv
module scr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: src/scr_ctrl.sv
module scr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  scr_pkg::dp_status_type status,
   output scr_pkg::dp_cmd_type   cmd
);
   import scr_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_KCHK,
      ST_SMUL_LO,
      ST_SMUL_HI,
      ST_SFIX,
      ST_CMUL_LO,
      ST_CMUL_HI,
      ST_KFIX,
      ST_INS_CHK,
      ST_INS_CMP,
      ST_COMMIT,
      ST_EMIT_RD,
      ST_EMIT_SLOT,
      ST_EMIT_LOAD,
      ST_EMIT_WAIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd.op   = DP_NOP;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (!status.full) begin
                  cmd.op   = DP_LOAD;
                  state_in = ST_KCHK;
               end else if (status.last) begin
                  // store full: drop the entry, still flush
                  state_in = ST_EMIT_RD;
               end
            end
         end
         ST_KCHK:    state_in = status.dim_zero ? ST_INS_CHK : ST_SMUL_LO;
         ST_SMUL_LO: begin cmd.op = DP_SMUL_LO; state_in = ST_SMUL_HI; end
         ST_SMUL_HI: begin cmd.op = DP_SMUL_HI; state_in = ST_SFIX;    end
         ST_SFIX:    begin cmd.op = DP_SFIX;    state_in = ST_CMUL_LO; end
         ST_CMUL_LO: begin cmd.op = DP_CMUL_LO; state_in = ST_CMUL_HI; end
         ST_CMUL_HI: begin cmd.op = DP_CMUL_HI; state_in = ST_KFIX;    end
         ST_KFIX:    begin cmd.op = DP_KFIX;    state_in = ST_KCHK;    end
         ST_INS_CHK: begin
            if (status.pos_zero) begin
               cmd.op   = DP_INS_PUT;
               state_in = ST_COMMIT;
            end else begin
               cmd.op   = DP_INS_RD;
               state_in = ST_INS_CMP;
            end
         end
         ST_INS_CMP: begin
            if (status.key_gt) begin
               cmd.op   = DP_INS_MOVE;
               state_in = ST_INS_CHK;
            end else begin
               cmd.op   = DP_INS_PUT;
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd.op   = DP_COMMIT;
            state_in = status.last ? ST_EMIT_RD : ST_IDLE;
         end
         ST_EMIT_RD:   begin cmd.op = DP_EMIT_RD;   state_in = ST_EMIT_SLOT; end
         ST_EMIT_SLOT: begin cmd.op = DP_EMIT_SLOT; state_in = ST_EMIT_LOAD; end
         ST_EMIT_LOAD: begin cmd.op = DP_EMIT_LOAD; state_in = ST_EMIT_WAIT; end
         ST_EMIT_WAIT: begin
            if (!rsp_stall) begin
               cmd.op   = DP_EMIT_NEXT;
               state_in = status.k_last ? ST_IDLE : ST_EMIT_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT_WAIT);
endmodule

FILE: src/scr_dp.sv
module scr_dp #(
   parameter int MAX_ENTRIES = 64
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  scr_pkg::dp_cmd_type                    cmd,
   output scr_pkg::dp_status_type                 status,
   input  logic                                   csr_we,
   input  logic [scr_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [scr_pkg::CSR_DAT_W-1:0]          csr_data,
   input  logic [scr_pkg::COORD_W-1:0]            in_coord [scr_pkg::MAX_DIMS],
   input  logic [scr_pkg::VALUE_W-1:0]            in_value,
   input  logic                                   in_last,
   output logic [scr_pkg::COORD_W-1:0]            out_coord [scr_pkg::MAX_DIMS],
   output logic [scr_pkg::VALUE_W-1:0]            out_value,
   output logic                                   out_last
);
   import scr_pkg::*;

   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int ROW_W = MAX_DIMS * COORD_W;
   localparam int SRT_W = KEY_W + IDX_W;

   logic [NDIM_W-1:0]  dim_count_ff;
   logic [COORD_W-1:0] dim_ff [MAX_DIMS];

   logic [CNT_W-1:0]   count_ff;
   logic               last_ff;
   logic [IDX_W-1:0]   pos_ff;
   logic [IDX_W-1:0]   k_ff;
   logic [DIDX_W-1:0]  d_ff;
   logic [COORD_W-1:0] cin_ff [MAX_DIMS];
   logic [KEY_W-1:0]   key_ff;
   logic [KEY_W-1:0]   stride_ff;
   logic [KEY_W-1:0]   prod_ff;
   logic [KEY_W-1:0]   tmp_ff;

   logic [COORD_W-1:0] out_coord_ff [MAX_DIMS];
   logic [VALUE_W-1:0] out_value_ff;
   logic               out_last_ff;

   logic [NDIM_W-1:0]  n_used;
   logic [COORD_W-1:0] cin_mask [MAX_DIMS];
   logic [ROW_W-1:0]   row_wr;
   logic [COORD_W-1:0] mul_a, mul_b;
   logic [IDX_W-1:0]   slot;
   logic               k_last;

   logic               srt_we;
   logic [IDX_W-1:0]   srt_raddr;
   logic [SRT_W-1:0]   srt_wdata, srt_rdata;
   logic               ent_we;
   logic [ROW_W-1:0]   row_rdata;
   logic [VALUE_W-1:0] val_rdata;

   assign slot   = count_ff[IDX_W-1:0];
   assign n_used = (dim_count_ff == '0) ? NDIM_W'(1) :
                   (dim_count_ff > NDIM_W'(MAX_DIMS)) ? NDIM_W'(MAX_DIMS) : dim_count_ff;
   assign k_last = (CNT_W'(k_ff) + CNT_W'(1)) == count_ff;

   always_comb begin
      for (int i = 0; i < MAX_DIMS; i++) begin
         cin_mask[i] = (NDIM_W'(i) < n_used) ? in_coord[i] : '0;
         row_wr[i*COORD_W +: COORD_W] = cin_mask[i];
      end
   end

   // one shared 32x32 multiplier, 64-bit mod products built from two halves
   always_comb begin
      mul_a = stride_ff[COORD_W-1:0];
      mul_b = dim_ff[d_ff];
      case (cmd.op)
         DP_SMUL_HI: mul_a = stride_ff[KEY_W-1:COORD_W];
         DP_CMUL_LO: begin
            mul_a = stride_ff[COORD_W-1:0];
            mul_b = cin_ff[d_ff - DIDX_W'(1)];
         end
         DP_CMUL_HI: begin
            mul_a = stride_ff[KEY_W-1:COORD_W];
            mul_b = cin_ff[d_ff - DIDX_W'(1)];
         end
         default: ;
      endcase
   end

   always_comb begin
      srt_we    = 1'b0;
      srt_wdata = {key_ff, slot};
      srt_raddr = k_ff;
      case (cmd.op)
         DP_INS_RD:   srt_raddr = pos_ff - IDX_W'(1);
         DP_INS_MOVE: begin
            srt_we    = 1'b1;
            srt_wdata = srt_rdata;
         end
         DP_INS_PUT:  srt_we = 1'b1;
         default: ;
      endcase
   end

   assign ent_we = (cmd.op == DP_LOAD);

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_count_ff <= NDIM_W'(1);
         for (int i = 0; i < MAX_DIMS; i++) begin
            dim_ff[i] <= COORD_W'(1);
         end
      end else if (csr_we) begin
         if (csr_index == CSR_DIM_COUNT) begin
            dim_count_ff <= csr_data[NDIM_W-1:0];
         end else begin
            dim_ff[csr_index] <= csr_data[COORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         k_ff     <= '0;
      end else begin
         case (cmd.op)
            DP_COMMIT: count_ff <= count_ff + CNT_W'(1);
            DP_EMIT_NEXT: begin
               if (k_last) begin
                  count_ff <= '0;
                  k_ff     <= '0;
               end else begin
                  k_ff <= k_ff + IDX_W'(1);
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= KEY_W'(mul_a) * KEY_W'(mul_b);
      case (cmd.op)
         DP_LOAD: begin
            cin_ff    <= cin_mask;
            key_ff    <= KEY_W'(cin_mask[DIDX_W'(n_used - NDIM_W'(1))]);
            stride_ff <= KEY_W'(1);
            d_ff      <= DIDX_W'(n_used - NDIM_W'(1));
            pos_ff    <= slot;
         end
         DP_SMUL_HI: tmp_ff <= prod_ff;
         DP_SFIX:    stride_ff <= tmp_ff + {prod_ff[COORD_W-1:0], {COORD_W{1'b0}}};
         DP_CMUL_HI: tmp_ff <= prod_ff;
         DP_KFIX: begin
            key_ff <= key_ff + tmp_ff + {prod_ff[COORD_W-1:0], {COORD_W{1'b0}}};
            d_ff   <= d_ff - DIDX_W'(1);
         end
         DP_INS_MOVE: pos_ff <= pos_ff - IDX_W'(1);
         DP_EMIT_LOAD: begin
            for (int i = 0; i < MAX_DIMS; i++) begin
               out_coord_ff[i] <= row_rdata[i*COORD_W +: COORD_W];
            end
            out_value_ff <= val_rdata;
            out_last_ff  <= k_last;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= 1'b0;
      end else if (ent_we) begin
         last_ff <= in_last;
      end
   end

   // sorted list of {key, slot}
   scr_ram #(.WIDTH(SRT_W), .DEPTH(MAX_ENTRIES)) u_sort_ram (
      .clock   (clock),
      .wr_en   (srt_we),
      .wr_addr (pos_ff),
      .wr_data (srt_wdata),
      .rd_addr (srt_raddr),
      .rd_data (srt_rdata)
   );

   scr_ram #(.WIDTH(ROW_W), .DEPTH(MAX_ENTRIES)) u_coord_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (slot),
      .wr_data (row_wr),
      .rd_addr (srt_rdata[IDX_W-1:0]),
      .rd_data (row_rdata)
   );

   scr_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ENTRIES)) u_value_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (slot),
      .wr_data (in_value),
      .rd_addr (srt_rdata[IDX_W-1:0]),
      .rd_data (val_rdata)
   );

   // when full the waiting beat is dropped, so its last flag is taken live
   assign status.full     = (count_ff == CNT_W'(MAX_ENTRIES));
   assign status.last     = (count_ff == CNT_W'(MAX_ENTRIES)) ? in_last : last_ff;
   assign status.dim_zero = (d_ff == '0);
   assign status.pos_zero = (pos_ff == '0);
   assign status.key_gt   = (srt_rdata[SRT_W-1:IDX_W] > key_ff);
   assign status.k_last   = k_last;

   assign out_coord = out_coord_ff;
   assign out_value = out_value_ff;
   assign out_last  = out_last_ff;
endmodule
